[sv/fmp_pkg.sv]
// Package for the Fibonacci-remainder core: microcode word types, program
// counter codes and the control store. No dependencies.
package fmp_pkg;

    // Program counter of the sequencer, one code per control-store entry.
    typedef enum logic [2:0] {
        U_IDLE   = 3'd0,
        U_CHECK  = 3'd1,
        U_SEARCH = 3'd2,
        U_DINIT  = 3'd3,
        U_DIV    = 3'd4,
        U_WALK   = 3'd5,
        U_OUTPUT = 3'd6
    } t_upc;

    // Datapath action selected by a control word.
    typedef enum logic [2:0] {
        A_NONE,
        A_LOAD,
        A_FIB_STEP,
        A_DIV_INIT,
        A_DIV_STEP,
        A_WALK_STEP
    } t_action;

    // Condition tested by a control word.
    typedef enum logic [2:0] {
        C_NEVER,
        C_IN_VALID,
        C_MOD_ZERO,
        C_PERIOD_FOUND,
        C_CNT_ZERO,
        C_REM_ZERO,
        C_OUT_READY
    } t_cond;

    // Sequencing mode.
    //   M_NEXT: perform the action, go to target if the condition holds, else fall through.
    //   M_LOOP: go to target if the condition holds, else perform the action and stay.
    //   M_WAIT: if the condition holds perform the action and go to target, else stay.
    typedef enum logic [1:0] {
        M_NEXT,
        M_LOOP,
        M_WAIT
    } t_mode;

    typedef struct packed {
        logic    in_rdy;
        logic    out_vld;
        t_action action;
        t_cond   cond;
        t_mode   mode;
        t_upc    target;
    } t_uword;

    // Control store.
    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        w = '{in_rdy: 1'b0, out_vld: 1'b0, action: A_NONE, cond: C_NEVER,
              mode: M_NEXT, target: U_IDLE};
        unique case (pc)
            U_IDLE: begin
                w = '{1'b1, 1'b0, A_LOAD, C_IN_VALID, M_WAIT, U_CHECK};
            end
            U_CHECK: begin
                w = '{1'b0, 1'b0, A_NONE, C_MOD_ZERO, M_NEXT, U_OUTPUT};
            end
            U_SEARCH: begin
                w = '{1'b0, 1'b0, A_FIB_STEP, C_PERIOD_FOUND, M_LOOP, U_DINIT};
            end
            U_DINIT: begin
                w = '{1'b0, 1'b0, A_DIV_INIT, C_NEVER, M_NEXT, U_DIV};
            end
            U_DIV: begin
                w = '{1'b0, 1'b0, A_DIV_STEP, C_CNT_ZERO, M_LOOP, U_WALK};
            end
            U_WALK: begin
                w = '{1'b0, 1'b0, A_WALK_STEP, C_REM_ZERO, M_LOOP, U_OUTPUT};
            end
            U_OUTPUT: begin
                w = '{1'b0, 1'b1, A_NONE, C_OUT_READY, M_WAIT, U_IDLE};
            end
            default: begin
                w = '{1'b0, 1'b0, A_NONE, C_NEVER, M_NEXT, U_IDLE};
            end
        endcase
        return w;
    endfunction

endpackage

[sv/fmp_if.sv]
// Handshake channels of the Fibonacci-remainder core: the request channel
// and the result channel. No dependencies.
interface fmp_in_if #(
    parameter int MOD_BITS   = 16,
    parameter int INDEX_BITS = 63
);
    logic                  valid;
    logic                  ready;
    logic [INDEX_BITS-1:0] fib_index;
    logic [MOD_BITS-1:0]   modulus;

    modport source (output valid, output fib_index, output modulus, input ready);
    modport sink   (input valid, input fib_index, input modulus, output ready);
endinterface

interface fmp_out_if #(
    parameter int MOD_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] remainder;
    logic                error;

    modport source (output valid, output remainder, output error, input ready);
    modport sink   (input valid, input remainder, input error, output ready);
endinterface

[sv/fibonacci_mod_pisano_core.sv]
// Top level of the Fibonacci-remainder core: microcoded sequencer and datapath.
// Depends on fmp_pkg and the channel interfaces in fmp_if.sv.
//
// The core takes one request beat (fib_index n, modulus m) and returns one
// result beat holding F(n) mod m, with F(0)=0 and F(1)=1. A zero modulus sets
// error and returns a remainder of zero. Work is done one request at a time
// by a small program in a control store that drives one shared mod-m adder,
// a bit-serial restoring divider and a few counters. For a nonzero modulus a
// request passes through the zero check, the period search for p, the Pisano
// period of m (at most 6m), the divider setup, the reduction of n modulo p,
// the final walk of (n mod p) Fibonacci steps and the result beat. The period
// search and the final walk take one Fibonacci step per cycle through the
// shared adder, and the reduction of n takes one index bit per cycle. A zero
// modulus goes from the zero check straight to the result beat. A new request
// is taken once the result beat has been accepted by the sink.
module fibonacci_mod_pisano_core
    import fmp_pkg::*;
#(
    parameter int MOD_BITS   = 16,
    parameter int INDEX_BITS = 63
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fmp_in_if.sink    i_item,
    fmp_out_if.source o_result
);

    // The period is at most 6m, which fits in three bits more than m.
    localparam int PW = MOD_BITS + 3;
    localparam int CW = $clog2(INDEX_BITS + 1);

    t_upc                  r_pc;
    t_upc                  n_pc;
    t_uword                uw;
    logic                  cond_true;
    logic                  do_act;

    logic [INDEX_BITS-1:0] r_n;
    logic [MOD_BITS-1:0]   r_m;
    logic [MOD_BITS-1:0]   r_a;
    logic [MOD_BITS-1:0]   r_b;
    logic                  r_start_b;
    logic [PW-1:0]         r_steps;
    logic [PW-1:0]         r_cap;
    logic [PW-1:0]         r_rem;
    logic [CW-1:0]         r_cnt;

    logic [MOD_BITS:0]     fib_sum;
    logic [MOD_BITS-1:0]   fib_next;
    logic [PW:0]           div_trial;
    logic [PW-1:0]         div_next;
    logic [MOD_BITS-1:0]   start_b_word;
    logic                  period_found;

    assign uw = ucode_rom(r_pc);

    // Shared mod-m adder: both operands are below m, so one subtract suffices.
    always_comb begin
        fib_sum = {1'b0, r_a} + {1'b0, r_b};
        if (fib_sum >= {1'b0, r_m}) begin
            fib_next = MOD_BITS'(fib_sum - {1'b0, r_m});
        end else begin
            fib_next = MOD_BITS'(fib_sum);
        end
    end

    // One restoring division step of n by the period, most significant bit first.
    always_comb begin
        div_trial = {r_rem, r_n[INDEX_BITS-1]};
        if (div_trial >= {1'b0, r_steps}) begin
            div_next = PW'(div_trial - {1'b0, r_steps});
        end else begin
            div_next = PW'(div_trial);
        end
    end

    assign start_b_word = {{(MOD_BITS-1){1'b0}}, r_start_b};

    // The pair has come back to its start, or the search hit its step bound.
    assign period_found = (r_steps >= r_cap)
                       || ((r_steps != '0) && (r_a == '0) && (r_b == start_b_word));

    always_comb begin
        unique case (uw.cond)
            C_NEVER:        cond_true = 1'b0;
            C_IN_VALID:     cond_true = i_item.valid;
            C_MOD_ZERO:     cond_true = (r_m == '0);
            C_PERIOD_FOUND: cond_true = period_found;
            C_CNT_ZERO:     cond_true = (r_cnt == '0);
            C_REM_ZERO:     cond_true = (r_rem == '0);
            C_OUT_READY:    cond_true = o_result.ready;
            default:        cond_true = 1'b0;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        unique case (uw.mode)
            M_NEXT:  n_pc = cond_true ? uw.target : t_upc'(r_pc + 3'd1);
            M_LOOP:  n_pc = cond_true ? uw.target : r_pc;
            M_WAIT:  n_pc = cond_true ? uw.target : r_pc;
            default: n_pc = U_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        unique case (uw.mode)
            M_NEXT:  do_act = 1'b1;
            M_LOOP:  do_act = !cond_true;
            M_WAIT:  do_act = cond_true;
            default: do_act = 1'b0;
        endcase
    end

    assign i_item.ready       = uw.in_rdy;
    assign o_result.valid     = uw.out_vld;
    assign o_result.error     = (r_m == '0);
    assign o_result.remainder = (r_m == '0) ? '0 : r_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= U_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_act) begin
            unique case (uw.action)
                A_NONE: begin
                end
                A_LOAD: begin
                    r_n       <= i_item.fib_index;
                    r_m       <= i_item.modulus;
                    r_start_b <= (i_item.modulus != MOD_BITS'(1));
                    r_a       <= '0;
                    r_b       <= {{(MOD_BITS-1){1'b0}}, (i_item.modulus != MOD_BITS'(1))};
                    r_steps   <= '0;
                    r_cap     <= {1'b0, i_item.modulus, 2'b00}
                               + {2'b00, i_item.modulus, 1'b0};
                end
                A_FIB_STEP: begin
                    r_a     <= r_b;
                    r_b     <= fib_next;
                    r_steps <= r_steps + PW'(1);
                end
                A_DIV_INIT: begin
                    r_rem <= '0;
                    r_cnt <= CW'(INDEX_BITS);
                    r_a   <= '0;
                    r_b   <= start_b_word;
                end
                A_DIV_STEP: begin
                    r_rem <= div_next;
                    r_n   <= {r_n[INDEX_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt - CW'(1);
                end
                A_WALK_STEP: begin
                    r_a   <= r_b;
                    r_b   <= fib_next;
                    r_rem <= r_rem - PW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // A result without error always lies below the modulus.
    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.error) |-> (o_result.remainder < r_m))
        else $error("remainder not reduced below modulus");

    // An accepted request always moves the sequencer to the zero-modulus check.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_pc == U_CHECK))
        else $error("sequencer did not start after accepting a request");

    // The period search never runs past its step bound.
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == U_SEARCH) |-> (r_steps <= r_cap))
        else $error("period search ran past its bound");

    // The walk length is the reduced index, so it stays below the period.
    a_walk_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == U_WALK) |-> (r_rem < r_steps))
        else $error("reduced index not below the period");

endmodule
